// File: src/twc_pkg.sv
// shared types, constants and round functions of the three-way block cipher
package twc_pkg;

  // command codes
  localparam logic CMD_ENCRYPT = 1'b0;
  localparam logic CMD_DECRYPT = 1'b1;

  // configuration register indexes
  localparam logic [1:0] REG_KEY_ZERO = 2'd0;
  localparam logic [1:0] REG_KEY_ONE  = 2'd1;
  localparam logic [1:0] REG_KEY_TWO  = 2'd2;

  // round constant generator
  localparam logic [15:0] ENC_START  = 16'h0b0b;
  localparam logic [15:0] DEC_START  = 16'hb1b1;
  localparam logic [15:0] CONST_POLY = 16'h1011;

  // three 32-bit words, index 0 is the first big-endian word
  typedef logic [2:0][31:0] twc_block_t;

  // one transaction as it travels down the pipeline
  typedef struct packed {
    logic       cmd;
    twc_block_t blk;
  } twc_data_t;

  // forward key and inverse key, both needed by every stage
  typedef struct packed {
    twc_block_t enc;
    twc_block_t dec;
  } twc_key_t;

  // round constant after idx generator steps, evaluated at elaboration
  function automatic logic [15:0] round_const(logic [15:0] start, int unsigned idx);
    logic [15:0] c;
    logic [15:0] n;
    c = start;
    for (int unsigned i = 0; i < idx; i++) begin
      n = {c[14:0], 1'b0};
      if (c[15]) begin
        n = n ^ CONST_POLY;
      end
      c = n;
    end
    return c;
  endfunction

  function automatic logic [31:0] bit_rev(logic [31:0] v);
    logic [31:0] r;
    for (int i = 0; i < 32; i++) begin
      r[i] = v[31-i];
    end
    return r;
  endfunction

  function automatic logic [31:0] theta_word(logic [31:0] a, logic [31:0] b,
                                             logic [31:0] c);
    return a ^ (a >> 16) ^ (b << 16) ^ (b >> 16) ^ (c << 16) ^
           (b >> 24) ^ (c << 8) ^ (c >> 8) ^ (a << 24) ^
           (c >> 16) ^ (a << 16) ^ (c >> 24) ^ (a << 8);
  endfunction

  function automatic twc_block_t theta(twc_block_t w);
    twc_block_t t;
    t[0] = theta_word(w[0], w[1], w[2]);
    t[1] = theta_word(w[1], w[2], w[0]);
    t[2] = theta_word(w[2], w[0], w[1]);
    return t;
  endfunction

  // bit reversal of every word with the outer words swapped
  function automatic twc_block_t mu(twc_block_t w);
    twc_block_t t;
    t[0] = bit_rev(w[2]);
    t[1] = bit_rev(w[1]);
    t[2] = bit_rev(w[0]);
    return t;
  endfunction

  function automatic twc_block_t gamma_nl(twc_block_t w);
    twc_block_t t;
    t[0] = w[0] ^ (w[1] | ~w[2]);
    t[1] = w[1] ^ (w[2] | ~w[0]);
    t[2] = w[2] ^ (w[0] | ~w[1]);
    return t;
  endfunction

  // theta, pi_1, gamma, pi_2
  function automatic twc_block_t rho(twc_block_t w);
    twc_block_t t;
    t = theta(w);
    t[0] = {t[0][9:0], t[0][31:10]};
    t[2] = {t[2][30:0], t[2][31]};
    t = gamma_nl(t);
    t[2] = {t[2][9:0], t[2][31:10]};
    t[0] = {t[0][30:0], t[0][31]};
    return t;
  endfunction

  function automatic twc_block_t key_mix(twc_block_t w, twc_block_t k,
                                         logic [15:0] rc);
    twc_block_t t;
    t[0] = w[0] ^ k[0] ^ {rc, 16'h0000};
    t[1] = w[1] ^ k[1];
    t[2] = w[2] ^ k[2] ^ {16'h0000, rc};
    return t;
  endfunction

endpackage

// File: src/twc_round.sv
// one cipher round as a registered pipeline stage
module twc_round #(
  parameter int unsigned ROUND = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                up_valid,
  output logic                up_ready,
  input  twc_pkg::twc_data_t  up_data,
  input  twc_pkg::twc_key_t   key,
  output logic                dn_valid,
  input  logic                dn_ready,
  output twc_pkg::twc_data_t  dn_data
);
  import twc_pkg::*;

  localparam logic [15:0] RC_ENC = round_const(ENC_START, ROUND);
  localparam logic [15:0] RC_DEC = round_const(DEC_START, ROUND);

  logic        valid;
  twc_data_t   data;
  twc_data_t   data_next;
  logic [15:0] rc;
  twc_block_t  rk;

  // constant and key follow the command of the transaction in flight
  always_comb begin
    rc = (up_data.cmd == CMD_DECRYPT) ? RC_DEC : RC_ENC;
    rk = (up_data.cmd == CMD_DECRYPT) ? key.dec : key.enc;
    data_next.cmd = up_data.cmd;
    data_next.blk = rho(key_mix(up_data.blk, rk, rc));
  end

  // stage takes a new transaction when empty or when its content moves on
  assign up_ready = !valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data <= data_next;
    end
  end

  assign dn_valid = valid;
  assign dn_data  = data;

endmodule

// File: src/twc_final.sv
// closing key mix and theta, plus exit mu for decrypt, held in the output register
module twc_final #(
  parameter int unsigned ROUND_COUNT = 11
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                up_valid,
  output logic                up_ready,
  input  twc_pkg::twc_data_t  up_data,
  input  twc_pkg::twc_key_t   key,
  output logic                dn_valid,
  input  logic                dn_ready,
  output twc_pkg::twc_block_t dn_blk
);
  import twc_pkg::*;

  localparam logic [15:0] RC_ENC = round_const(ENC_START, ROUND_COUNT);
  localparam logic [15:0] RC_DEC = round_const(DEC_START, ROUND_COUNT);

  logic       valid;
  twc_block_t blk;
  twc_block_t blk_next;
  twc_block_t mixed;

  // final mix and theta, decrypt leaves through mu
  always_comb begin
    if (up_data.cmd == CMD_DECRYPT) begin
      mixed    = theta(key_mix(up_data.blk, key.dec, RC_DEC));
      blk_next = mu(mixed);
    end else begin
      mixed    = theta(key_mix(up_data.blk, key.enc, RC_ENC));
      blk_next = mixed;
    end
  end

  assign up_ready = !valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      blk <= blk_next;
    end
  end

  assign dn_valid = valid;
  assign dn_blk   = blk;

endmodule

// File: src/three_way_block_cipher.sv
// 3-Way 96-bit block cipher, fully pipelined with one round per stage.
// One block enters per clock cycle while input is not held off. Each of
// the ROUND_COUNT round stages holds one round, and the output register
// holds the closing key mix and theta (and the exit mu for decrypt).
// Every stage has its own valid bit and advances when empty or when its
// successor takes its content, so a stall on the result side fills
// empty stages before input is held off. The user must write the key
// through the configuration port only while no transaction is in flight;
// the block itself does not enforce it. The inverse key for decryption is derived from it without extra latency.
module three_way_block_cipher #(
  parameter int unsigned ROUND_COUNT = 11
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [31:0] block_word_zero,
  input  logic [31:0] block_word_one,
  input  logic [31:0] block_word_two,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] result_word_zero,
  output logic [31:0] result_word_one,
  output logic [31:0] result_word_two
);
  import twc_pkg::*;

  twc_block_t key_reg;
  twc_key_t   key;
  twc_data_t  entry;
  twc_block_t res;

  logic      stage_valid [ROUND_COUNT+1];
  logic      stage_ready [ROUND_COUNT+1];
  twc_data_t stage_data  [ROUND_COUNT+1];

  logic [ROUND_COUNT:0] occupied;

  // key registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_reg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_KEY_ZERO: key_reg[0] <= cfg_data;
        REG_KEY_ONE:  key_reg[1] <= cfg_data;
        REG_KEY_TWO:  key_reg[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // forward and inverse key
  always_comb begin
    key.enc = key_reg;
    key.dec = mu(theta(key_reg));
  end

  // decrypt enters through mu, which is only wiring
  always_comb begin
    entry.cmd    = command;
    entry.blk[0] = block_word_zero;
    entry.blk[1] = block_word_one;
    entry.blk[2] = block_word_two;
    if (command == CMD_DECRYPT) begin
      entry.blk = mu(entry.blk);
    end
  end

  assign stage_valid[0] = in_valid;
  assign stage_data[0]  = entry;
  assign in_ready       = stage_ready[0];

  // round stages
  for (genvar r = 0; r < ROUND_COUNT; r++) begin : g_round
    twc_round #(
      .ROUND(r)
    ) u_round (
      .clk      (clk),
      .rst      (rst),
      .up_valid (stage_valid[r]),
      .up_ready (stage_ready[r]),
      .up_data  (stage_data[r]),
      .key      (key),
      .dn_valid (stage_valid[r+1]),
      .dn_ready (stage_ready[r+1]),
      .dn_data  (stage_data[r+1])
    );
    assign occupied[r] = stage_valid[r+1];
  end

  // closing stage and output register
  twc_final #(
    .ROUND_COUNT(ROUND_COUNT)
  ) u_final (
    .clk      (clk),
    .rst      (rst),
    .up_valid (stage_valid[ROUND_COUNT]),
    .up_ready (stage_ready[ROUND_COUNT]),
    .up_data  (stage_data[ROUND_COUNT]),
    .key      (key),
    .dn_valid (out_valid),
    .dn_ready (out_ready),
    .dn_blk   (res)
  );

  assign occupied[ROUND_COUNT] = out_valid;

  assign result_word_zero = res[0];
  assign result_word_one  = res[1];
  assign result_word_two  = res[2];

  // transactions in flight change only by accepted input and taken output
  a_occupancy: assert property (@(posedge clk) disable iff (rst)
    !rst |=> ($countones(occupied) ==
              $past($countones(occupied)) + int'($past(in_valid && in_ready))
              - int'($past(out_valid && out_ready))))
    else $error("pipeline occupancy mismatch");

  // input is held off only when every stage is full and the output stalls
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (&occupied && !out_ready))
    else $error("input stalled with room in the pipeline");

  // an accepted transaction lands in the first round stage
  a_entry: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> occupied[0])
    else $error("accepted transaction lost at entry");

endmodule

// File: test/cipher_checker.sv
`timescale 1ns / 1ps
// checker for the three-way block cipher: predicts every block and compares the results
module cipher_checker #(
  parameter int unsigned ROUNDS = 11
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        command,
  input  logic [31:0] block_word_zero,
  input  logic [31:0] block_word_one,
  input  logic [31:0] block_word_two,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] result_word_zero,
  input  logic [31:0] result_word_one,
  input  logic [31:0] result_word_two,
  output int          fail_count,
  output int          blocks_in_flight,
  output int          blocks_checked,
  output int          decrypts_sent
);
  import twc_pkg::*;

  // index 0 is the first big-endian word
  typedef logic [2:0][31:0] triple_t;

  triple_t key_words = '0;
  triple_t expected_blocks[$];
  int fail_total = 0;
  int checked_total = 0;
  int decrypt_total = 0;

  function automatic logic [31:0] mirror(logic [31:0] v);
    logic [31:0] r;
    for (int i = 0; i < 32; i++) begin
      r[31-i] = v[i];
    end
    return r;
  endfunction

  // linear mixing layer, each word folds in its two neighbors
  function automatic triple_t diffuse(triple_t x);
    triple_t y;
    logic [31:0] a, b, c;
    for (int i = 0; i < 3; i++) begin
      a = x[i];
      b = x[(i + 1) % 3];
      c = x[(i + 2) % 3];
      y[i] = a ^ (a >> 16) ^ (a << 16) ^ (a << 8) ^ (a << 24) ^
             (b << 16) ^ (b >> 16) ^ (b >> 24) ^
             (c << 16) ^ (c >> 16) ^ (c << 8) ^ (c >> 8) ^ (c >> 24);
    end
    return y;
  endfunction

  // reverse all bits of the 96-bit block
  function automatic triple_t flip(triple_t x);
    triple_t y;
    y[0] = mirror(x[2]);
    y[1] = mirror(x[1]);
    y[2] = mirror(x[0]);
    return y;
  endfunction

  function automatic triple_t nonlinear(triple_t x);
    triple_t y;
    y[0] = x[0] ^ (x[1] | ~x[2]);
    y[1] = x[1] ^ (x[2] | ~x[0]);
    y[2] = x[2] ^ (x[0] | ~x[1]);
    return y;
  endfunction

  // mixing, word rotations around the nonlinear layer
  function automatic triple_t round_fn(triple_t x);
    triple_t y;
    y = diffuse(x);
    y[0] = {y[0][9:0], y[0][31:10]};
    y[2] = {y[2][30:0], y[2][31]};
    y = nonlinear(y);
    y[2] = {y[2][9:0], y[2][31:10]};
    y[0] = {y[0][30:0], y[0][31]};
    return y;
  endfunction

  function automatic triple_t add_key(triple_t x, triple_t k, logic [15:0] rc);
    triple_t y;
    y[0] = x[0] ^ k[0] ^ {rc, 16'h0000};
    y[1] = x[1] ^ k[1];
    y[2] = x[2] ^ k[2] ^ {16'h0000, rc};
    return y;
  endfunction

  function automatic logic [15:0] step_const(logic [15:0] c);
    return {c[14:0], 1'b0} ^ (c[15] ? CONST_POLY : 16'h0000);
  endfunction

  // full encryption or decryption of one block
  function automatic triple_t cipher_block(logic decrypt, triple_t blk, triple_t key);
    triple_t w, k;
    logic [15:0] rc;
    w = blk;
    k = key;
    rc = ENC_START;
    if (decrypt) begin
      k = flip(diffuse(key));
      w = flip(blk);
      rc = DEC_START;
    end
    for (int r = 0; r < ROUNDS; r++) begin
      w = round_fn(add_key(w, k, rc));
      rc = step_const(rc);
    end
    w = diffuse(add_key(w, k, rc));
    if (decrypt) begin
      w = flip(w);
    end
    return w;
  endfunction

  always @(posedge clk) begin : watch
    triple_t got, want;
    bit bad;
    if (rst) begin
      key_words = '0;
      expected_blocks.delete();
    end else begin
      // result transaction against the oldest expectation
      if (out_valid && out_ready) begin
        got = {result_word_two, result_word_one, result_word_zero};
        if (expected_blocks.size() == 0) begin
          if (fail_total < 10) begin
            $display("unexpected result %h %h %h at %0t", got[0], got[1], got[2], $time);
          end
          fail_total++;
        end else begin
          want = expected_blocks.pop_front();
          bad = 1'b0;
          for (int i = 0; i < 3; i++) begin
            if (got[i] !== want[i]) begin
              if (fail_total < 10) begin
                $display("result word %0d mismatch at %0t: expected %h, got %h",
                         i, $time, want[i], got[i]);
              end
              bad = 1'b1;
            end
          end
          if (bad) begin
            fail_total++;
          end
          checked_total++;
        end
      end
      // input transaction, predicted with the key as it stands
      if (in_valid && in_ready) begin
        expected_blocks.push_back(cipher_block(command == CMD_DECRYPT,
            {block_word_two, block_word_one, block_word_zero}, key_words));
        if (command == CMD_DECRYPT) begin
          decrypt_total++;
        end
      end
      // key register transaction, unused index is dropped
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_KEY_ZERO: key_words[0] = cfg_data;
          REG_KEY_ONE:  key_words[1] = cfg_data;
          REG_KEY_TWO:  key_words[2] = cfg_data;
          default: ;
        endcase
      end
    end
    fail_count <= fail_total;
    blocks_in_flight <= expected_blocks.size();
    blocks_checked <= checked_total;
    decrypts_sent <= decrypt_total;
  end

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// top of the three-way block cipher testbench: clock, reset, stimulus and verdict
module tb;
  import twc_pkg::*;

  localparam int unsigned ROUNDS = 11;
  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 92;
  localparam int SETTLE = ROUNDS + 20;
  localparam int DRAIN_LIMIT = 5000;
  localparam int LIMIT_NS = 5000000;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic        command;
  logic [31:0] block_word_zero;
  logic [31:0] block_word_one;
  logic [31:0] block_word_two;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] result_word_zero;
  logic [31:0] result_word_one;
  logic [31:0] result_word_two;

  int  fail_count;
  int  blocks_in_flight;
  int  blocks_checked;
  int  decrypts_sent;
  int  blocks_sent = 0;
  int  key_settings = 0;
  int  ready_hold = 0;
  bit  calm = 1'b0;

  always #6 clk = ~clk;

  three_way_block_cipher #(
    .ROUND_COUNT(ROUNDS)
  ) DUT (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .command          (command),
    .block_word_zero  (block_word_zero),
    .block_word_one   (block_word_one),
    .block_word_two   (block_word_two),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .result_word_zero (result_word_zero),
    .result_word_one  (result_word_one),
    .result_word_two  (result_word_two)
  );

  cipher_checker #(
    .ROUNDS(ROUNDS)
  ) u_checker (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .command          (command),
    .block_word_zero  (block_word_zero),
    .block_word_one   (block_word_one),
    .block_word_two   (block_word_two),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .result_word_zero (result_word_zero),
    .result_word_one  (result_word_one),
    .result_word_two  (result_word_two),
    .fail_count       (fail_count),
    .blocks_in_flight (blocks_in_flight),
    .blocks_checked   (blocks_checked),
    .decrypts_sent    (decrypts_sent)
  );

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int roll;
    roll = int'($urandom_range(99));
    if (roll < 55) begin
      return 0;
    end else if (roll < 85) begin
      return int'($urandom_range(3, 1));
    end else if (roll < 97) begin
      return int'($urandom_range(8, 4));
    end
    return int'($urandom_range(40, 15));
  endfunction

  // result side: mostly ready, with stalls of random length
  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      ready_hold <= 0;
    end else if (calm) begin
      out_ready  <= 1'b1;
      ready_hold <= 0;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      out_ready  <= !out_ready;
      ready_hold <= out_ready ? pick_gap() : pick_gap() + 2;
    end
  end

  // one key register transaction, valid stays up for the caller to drop
  task automatic write_key(input logic [1:0] idx, input logic [31:0] value);
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // one phase of block transactions, back to back or with gaps
  task automatic send_phase();
    int gap;
    logic [31:0] w0, w1, w2;
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if (i == 0) begin
        w0 = '0;
        w1 = '0;
        w2 = '0;
      end else if (i == 1) begin
        w0 = '1;
        w1 = '1;
        w2 = '1;
      end else begin
        w0 = $urandom();
        w1 = $urandom();
        w2 = $urandom();
      end
      command         <= ($urandom_range(1) == 0) ? CMD_ENCRYPT : CMD_DECRYPT;
      block_word_zero <= w0;
      block_word_one  <= w1;
      block_word_two  <= w2;
      in_valid        <= 1'b1;
      do @(posedge clk); while (!in_ready);
      blocks_sent++;
      gap = calm ? 0 : pick_gap();
      if (gap > 0 || i == PHASE_ITEMS - 1) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // wait until every predicted result has been taken, or until DRAIN_LIMIT runs out
  task automatic drain();
    int waited;
    waited = 0;
    @(posedge clk);
    while ((blocks_in_flight != 0 || out_valid) && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (2) @(posedge clk);
  endtask

  initial begin : stimulus
    rst             <= 1'b1;
    cfg_valid       <= 1'b0;
    cfg_index       <= REG_KEY_ZERO;
    cfg_data        <= '0;
    in_valid        <= 1'b0;
    command         <= CMD_ENCRYPT;
    block_word_zero <= '0;
    block_word_one  <= '0;
    block_word_two  <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int p = 0; p < PHASES; p++) begin
      // first phase runs on the key left by reset
      if (p == 1) begin
        write_key(REG_KEY_ZERO, '1);
        write_key(REG_KEY_ONE, '1);
        write_key(REG_KEY_TWO, '1);
        cfg_valid <= 1'b0;
        key_settings++;
      end else if (p > 1) begin
        write_key(REG_KEY_ZERO, $urandom());
        write_key(REG_KEY_ONE, $urandom());
        write_key(REG_KEY_TWO, $urandom());
        if (p == 3) begin
          write_key(REG_SPARE, $urandom());
        end
        cfg_valid <= 1'b0;
        key_settings++;
      end
      calm = (p == PHASES - 1);
      send_phase();
      drain();
    end

    repeat (SETTLE) @(posedge clk);
    $display("sent %0d blocks (%0d decrypts) under the reset key and %0d written keys,",
             blocks_sent, decrypts_sent, key_settings);
    $display("with random input gaps and result stalls; %0d results compared, %0d bad",
             blocks_checked, fail_count);
    if (fail_count == 0 && blocks_checked == blocks_sent && blocks_in_flight == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #(LIMIT_NS);
    $display("TB_ERROR: run did not finish in time");
    $finish;
  end

endmodule

// File: filelist.f
src/twc_pkg.sv
src/twc_round.sv
src/twc_final.sv
src/three_way_block_cipher.sv
test/cipher_checker.sv
test/tb.sv
